@@ hw/rtl/cfbd_pkg.sv @@
`default_nettype none

package cfbd_pkg;

   // Field widths of the channels
   localparam int BYTE_W  = 8;
   localparam int ID_W    = 11;
   localparam int COUNT_W = 4;
   localparam int POS_W   = 5;
   localparam int ADDR_W  = 8;

   // Register indexes on the csr channel
   localparam logic [ADDR_W-1:0] REG_START_MARKER = 8'd0;
   localparam logic [ADDR_W-1:0] REG_END_MARKER   = 8'd1;

   // Register reset values
   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h55;

   // Byte positions within a frame, start marker at zero
   localparam logic [POS_W-1:0] POS_LENGTH  = 5'd1;
   localparam logic [POS_W-1:0] POS_ID_LOW  = 5'd2;
   localparam logic [POS_W-1:0] POS_ID_HIGH = 5'd3;
   localparam logic [POS_W-1:0] HDR_BYTES   = 5'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FRAME,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take_start;   // start marker seen: position one next
      logic take_byte;    // frame byte: capture by position, advance
      logic clear_frame;  // leave the frame
      logic start_emit;   // rewind the result index
      logic load_out;     // load next result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_start;     // incoming byte equals start marker
      logic is_end;       // incoming byte equals end marker
      logic len_bad;      // length byte above the payload limit
      logic at_final;     // incoming byte is the frame's final byte
      logic emit_last;    // next result closes the run
      logic out_free;     // output register can take a result
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/cfbd_if.sv @@
`default_nettype none

interface cfbd_req_if;
   logic                          valid;
   logic                          ready;
   logic [cfbd_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cfbd_pkg::ID_W-1:0]     frame_id;
   logic [cfbd_pkg::COUNT_W-1:0]  data_count;
   logic [cfbd_pkg::COUNT_W-1:0]  byte_index;
   logic [cfbd_pkg::BYTE_W-1:0]   data_byte;
   logic                          last;

   modport source (output valid, output frame_id, output data_count, output byte_index,
                   output data_byte, output last, input ready);
   modport sink   (input valid, input frame_id, input data_count, input byte_index,
                   input data_byte, input last, output ready);
endinterface

interface cfbd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cfbd_pkg::ADDR_W-1:0]   index;
   logic [cfbd_pkg::BYTE_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/can_frame_byte_deframer.sv @@
`default_nettype none

// Channel   Dir   Payload                                           Handshake
// req_chan  in    rx_byte                                           valid/ready
// rsp_chan  out   frame_id, data_count, byte_index, data_byte, last valid/ready
// csr_chan  in    index (0 start marker, 1 end marker), data        valid/ready
//
// A received byte is taken while idle or inside a frame.
// A good end marker starts a run of max(data_count, 1) items, one per cycle
// while the consumer keeps ready high; req_chan stalls for the whole run,
// paced by the single output register.
// Synchronous reset restores the markers to their reset values and waits for start.
// csr_chan is always ready.

module can_frame_byte_deframer #(
   parameter int MAX_PAYLOAD = 15
) (
   input  wire              clock,
   input  wire              reset,
   cfbd_req_if.sink         req_chan,
   cfbd_rsp_if.source       rsp_chan,
   cfbd_csr_if.sink         csr_chan
);

   cfbd_pkg::cmd_type     cmd;
   cfbd_pkg::status_type  status;
   logic                  req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   cfbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfbd_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_chan.rx_byte),
      .csr_valid      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_frame_id   (rsp_chan.frame_id),
      .rsp_data_count (rsp_chan.data_count),
      .rsp_byte_index (rsp_chan.byte_index),
      .rsp_data_byte  (rsp_chan.data_byte),
      .rsp_last       (rsp_chan.last),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

`default_nettype wire

@@ hw/rtl/cfbd_ctrl.sv @@
`default_nettype none

module cfbd_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire cfbd_pkg::status_type status,
   output cfbd_pkg::cmd_type     cmd
);

   cfbd_pkg::state_type state_ff;
   cfbd_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfbd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cfbd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && status.is_start) begin
               cmd.take_start = 1'b1;
               state_in       = cfbd_pkg::ST_FRAME;
            end
         end
         cfbd_pkg::ST_FRAME: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.len_bad) begin
                  // drop the frame at an oversize length
                  cmd.clear_frame = 1'b1;
                  state_in        = cfbd_pkg::ST_IDLE;
               end else if (status.at_final) begin
                  cmd.clear_frame = 1'b1;
                  if (status.is_end) begin
                     cmd.start_emit = 1'b1;
                     state_in       = cfbd_pkg::ST_EMIT;
                  end else begin
                     state_in = cfbd_pkg::ST_IDLE;
                  end
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         cfbd_pkg::ST_EMIT: begin
            // push one result per free output slot
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.emit_last) begin
                  state_in = cfbd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cfbd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/cfbd_dp.sv @@
`default_nettype none

module cfbd_dp #(
   parameter int MAX_PAYLOAD = 15
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [cfbd_pkg::BYTE_W-1:0]        rx_byte,
   input  wire                                csr_valid,
   input  wire  [cfbd_pkg::ADDR_W-1:0]        csr_index,
   input  wire  [cfbd_pkg::BYTE_W-1:0]        csr_data,
   input  wire                                rsp_ready,
   output logic                               rsp_valid,
   output logic [cfbd_pkg::ID_W-1:0]          rsp_frame_id,
   output logic [cfbd_pkg::COUNT_W-1:0]       rsp_data_count,
   output logic [cfbd_pkg::COUNT_W-1:0]       rsp_byte_index,
   output logic [cfbd_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic                               rsp_last,
   input  wire  cfbd_pkg::cmd_type            cmd,
   output cfbd_pkg::status_type               status
);

   localparam int SLOT_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [cfbd_pkg::BYTE_W-1:0]  start_marker_ff;
   logic [cfbd_pkg::BYTE_W-1:0]  end_marker_ff;
   logic [cfbd_pkg::POS_W-1:0]   pos_ff;
   logic [cfbd_pkg::COUNT_W-1:0] length_ff;
   logic [cfbd_pkg::ID_W-1:0]    id_ff;
   logic [cfbd_pkg::COUNT_W-1:0] emit_idx_ff;
   logic [cfbd_pkg::BYTE_W-1:0]  payload_mem [MAX_PAYLOAD];

   logic                          rsp_valid_ff;
   logic [cfbd_pkg::ID_W-1:0]     out_id_ff;
   logic [cfbd_pkg::COUNT_W-1:0]  out_count_ff;
   logic [cfbd_pkg::COUNT_W-1:0]  out_index_ff;
   logic [cfbd_pkg::BYTE_W-1:0]   out_byte_ff;
   logic                          out_last_ff;

   logic [cfbd_pkg::POS_W-1:0]    slot;
   logic [cfbd_pkg::POS_W-1:0]    final_pos;

   assign slot      = pos_ff - cfbd_pkg::HDR_BYTES;
   assign final_pos = cfbd_pkg::HDR_BYTES + {1'b0, length_ff};

   // Status toward the controller
   always_comb begin
      status.is_start  = (rx_byte == start_marker_ff);
      status.is_end    = (rx_byte == end_marker_ff);
      status.len_bad   = (pos_ff == cfbd_pkg::POS_LENGTH) &&
                         (rx_byte[3:0] > cfbd_pkg::COUNT_W'(MAX_PAYLOAD));
      status.at_final  = (pos_ff >= final_pos);
      status.emit_last = (length_ff == '0) ||
                         ((emit_idx_ff + cfbd_pkg::COUNT_W'(1)) == length_ff);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= cfbd_pkg::START_MARKER_RESET;
         end_marker_ff   <= cfbd_pkg::END_MARKER_RESET;
      end else if (csr_valid) begin
         if (csr_index == cfbd_pkg::REG_START_MARKER) begin
            start_marker_ff <= csr_data;
         end else if (csr_index == cfbd_pkg::REG_END_MARKER) begin
            end_marker_ff <= csr_data;
         end
      end
   end

   // Frame position and header capture
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         length_ff <= '0;
         id_ff     <= '0;
      end else if (cmd.take_start) begin
         pos_ff <= cfbd_pkg::POS_LENGTH;
      end else if (cmd.clear_frame) begin
         pos_ff <= '0;
      end else if (cmd.take_byte) begin
         pos_ff <= pos_ff + cfbd_pkg::POS_W'(1);
         case (pos_ff)
            cfbd_pkg::POS_LENGTH: begin
               length_ff <= rx_byte[3:0];
            end
            cfbd_pkg::POS_ID_LOW: begin
               id_ff <= {3'b000, rx_byte};
            end
            cfbd_pkg::POS_ID_HIGH: begin
               id_ff[10:8] <= rx_byte[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Payload store write
   always_ff @(posedge clock) begin
      if (cmd.take_byte && (pos_ff >= cfbd_pkg::HDR_BYTES) &&
          (slot < cfbd_pkg::POS_W'(MAX_PAYLOAD))) begin
         payload_mem[slot[SLOT_W-1:0]] <= rx_byte;
      end
   end

   // Result index
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_idx_ff <= '0;
      end else if (cmd.start_emit) begin
         emit_idx_ff <= '0;
      end else if (cmd.load_out) begin
         emit_idx_ff <= emit_idx_ff + cfbd_pkg::COUNT_W'(1);
      end
   end

   // Output register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register: payload, read from the store
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_id_ff    <= id_ff;
         out_count_ff <= length_ff;
         out_index_ff <= emit_idx_ff;
         out_last_ff  <= status.emit_last;
         if (length_ff == '0) begin
            out_byte_ff <= '0;
         end else begin
            out_byte_ff <= payload_mem[emit_idx_ff[SLOT_W-1:0]];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_id   = out_id_ff;
   assign rsp_data_count = out_count_ff;
   assign rsp_byte_index = out_index_ff;
   assign rsp_data_byte  = out_byte_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire
